@@ hw/rtl/wesfl_pkg.sv @@
// shared types, codes and constants of the wheel end-stop force limiter
`default_nettype none
package wesfl_pkg;

  // field widths
  localparam int POS_W   = 14;
  localparam int REQ_W   = 16;
  localparam int FORCE_W = 15;
  localparam int RANGE_W = 10;
  localparam int GAIN_W  = 14;
  localparam int BND_W   = 13;
  localparam int CFG_W   = 14;
  localparam int CFG_IDX_W = 3;

  // input item packing
  localparam int IN_TDATA_W = 56;
  localparam int IN_TUSER_W = 2;
  // result item packing
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 3;

  // limits
  localparam int FORCE_LIMIT = 10000;
  localparam logic [RANGE_W-1:0] FULL_RANGE = RANGE_W'(900);
  localparam logic [RANGE_W-1:0] MIN_RANGE  = RANGE_W'(40);

  // scaling: every divide by 1e4 is a reciprocal multiply, exact for inputs
  // below 2^DIV_IN_W; the divide by 1e8 is split into two of them
  localparam int DIV_SCALE   = 10000;
  localparam int PROD_W      = 2 * GAIN_W;
  localparam int DIV_IN_W    = 29;
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 43;
  localparam logic [RECIP_W-1:0] RECIP_1E4 = RECIP_W'(879609303);
  localparam int QUOT_W      = DIV_IN_W + RECIP_W - RECIP_SHIFT;
  localparam int REM_W       = 14;
  localparam int SUM_W       = QUOT_W + 1;

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  // register reset values
  localparam logic [GAIN_W-1:0] RST_OVERALL_GAIN  = GAIN_W'(10000);
  localparam logic [GAIN_W-1:0] RST_PERIODIC_GAIN = GAIN_W'(10000);
  localparam logic [BND_W-1:0]  RST_BOUNDARY      = BND_W'(3000);
  localparam logic [POS_W-1:0]  RST_ENGAGE_LOW    = POS_W'(256);
  localparam logic [POS_W-1:0]  RST_RELEASE_LOW   = POS_W'(1024);
  localparam logic [POS_W-1:0]  RST_ENGAGE_HIGH   = POS_W'(16127);
  localparam logic [POS_W-1:0]  RST_RELEASE_HIGH  = POS_W'(15359);

  typedef enum logic [IN_TUSER_W-1:0] {
    KIND_POSITION = 2'd0,
    KIND_FORCE    = 2'd1,
    KIND_RANGE    = 2'd2,
    KIND_STOP_ALL = 2'd3
  } kind_t;

  typedef enum logic [OUT_TUSER_W-1:0] {
    ACT_SET_FORCE = 3'd0,
    ACT_STOP_SLOT = 3'd1,
    ACT_SET_RANGE = 3'd2,
    ACT_STOP_ALL  = 3'd3,
    ACT_REJECTED  = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERALL_GAIN  = 3'd0,
    CFG_PERIODIC_GAIN = 3'd1,
    CFG_BOUNDARY      = 3'd2,
    CFG_ENGAGE_LOW    = 3'd3,
    CFG_RELEASE_LOW   = 3'd4,
    CFG_ENGAGE_HIGH   = 3'd5,
    CFG_RELEASE_HIGH  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LOCK_NONE = 2'd0,
    LOCK_LOW  = 2'd1,
    LOCK_HIGH = 2'd2
  } lock_t;

  // classified command handed from front to back
  typedef enum logic [2:0] {
    OP_POSITION = 3'd0,
    OP_FORCE    = 3'd1,
    OP_RANGE    = 3'd2,
    OP_REJECT   = 3'd3,
    OP_STOP_ALL = 3'd4
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [POS_W-1:0]           position;
    logic signed [FORCE_W-1:0]  force_req;
    logic signed [FORCE_W-1:0]  periodic_req;
    logic [RANGE_W-1:0]         range_req;
  } cmd_t;

  // one result item
  typedef struct packed {
    action_t                    action;
    logic signed [FORCE_W-1:0]  force_value;
    logic [RANGE_W-1:0]         range_value;
    logic                       last;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/wheel_end_stop_force_limiter.sv @@
// top level of the wheel end-stop force limiter
// Soft end stop for a force-feedback wheel. Each input transfer carries one
// command (position sample, constant force request, set range or stop all)
// and causes zero, one or two result transfers, the final one marked by
// tlast. The front end clamps the requests, checks the range window and
// queues the command in a two-entry queue; the back end owns the settings,
// lock state and base force and feeds a single output register, so new
// inputs keep queueing while a result waits to be taken. Position samples,
// range changes and stop-all are done as they leave the queue, and a lock
// released by a range change then loads the base force as a second result.
// A force request keeps the back end busy through operand capture, six
// multiply and reciprocal-multiply steps in the scaling unit (1e8 handled
// as two divides by 1e4), the base force update and, with no lock held, the
// result load; no new command is taken meanwhile. Output stalls delay it too.
// The user must write settings through the cfg channel (always ready) only
// while idle; the block does not enforce this. Index 7 is ignored.
`default_nettype none
module wheel_end_stop_force_limiter (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input stream
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // position[13:0], force_request[29:14], periodic_request[45:30],
  // range_request[55:46]
  input  wire logic [wesfl_pkg::IN_TDATA_W-1:0]      s_tdata,
  // kind[1:0]
  input  wire logic [wesfl_pkg::IN_TUSER_W-1:0]      s_tuser,
  // result stream
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // force_value[14:0], range_value[24:15], zero fill[31:25]
  output logic [wesfl_pkg::OUT_TDATA_W-1:0]          m_tdata,
  // action[2:0]
  output logic [wesfl_pkg::OUT_TUSER_W-1:0]          m_tuser,
  output logic                                       m_tlast,
  // settings write channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [wesfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [wesfl_pkg::CFG_W-1:0]           cfg_data
);

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_not_empty;
  wesfl_pkg::cmd_t    q_cmd;
  wesfl_pkg::cmd_t    q_head;
  wesfl_pkg::result_t out_item;

  // classify and clamp on the way in
  wesfl_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // decouples the front from a busy back end
  wesfl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // executes commands and holds the result register
  wesfl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_item    (out_item)
  );

  // pack the result transfer
  assign m_tdata = {(wesfl_pkg::OUT_TDATA_W - wesfl_pkg::FORCE_W - wesfl_pkg::RANGE_W)'(0),
                    out_item.range_value, out_item.force_value};
  assign m_tuser = out_item.action;
  assign m_tlast = out_item.last;

endmodule
`default_nettype wire

@@ hw/rtl/wesfl_front.sv @@
// front end: accepts input items, clamps requests and classifies them
`default_nettype none
module wesfl_front (
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [wesfl_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  wire logic [wesfl_pkg::IN_TUSER_W-1:0]    s_tuser,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output wesfl_pkg::cmd_t                          q_cmd
);

  logic [wesfl_pkg::POS_W-1:0]          position;
  logic signed [wesfl_pkg::REQ_W-1:0]   force_request;
  logic signed [wesfl_pkg::REQ_W-1:0]   periodic_request;
  logic [wesfl_pkg::RANGE_W-1:0]        range_request;
  wesfl_pkg::kind_t                     kind;

  function automatic logic signed [wesfl_pkg::FORCE_W-1:0] clamp_req(
    input logic signed [wesfl_pkg::REQ_W-1:0] v
  );
    logic signed [wesfl_pkg::FORCE_W-1:0] r;
    if (v > wesfl_pkg::REQ_W'(wesfl_pkg::FORCE_LIMIT)) begin
      r = wesfl_pkg::FORCE_W'(wesfl_pkg::FORCE_LIMIT);
    end else if (v < -wesfl_pkg::REQ_W'(wesfl_pkg::FORCE_LIMIT)) begin
      r = -wesfl_pkg::FORCE_W'(wesfl_pkg::FORCE_LIMIT);
    end else begin
      r = v[wesfl_pkg::FORCE_W-1:0];
    end
    return r;
  endfunction

  assign position         = s_tdata[13:0];
  assign force_request    = s_tdata[29:14];
  assign periodic_request = s_tdata[45:30];
  assign range_request    = s_tdata[55:46];
  assign kind             = wesfl_pkg::kind_t'(s_tuser);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_cmd.position     = position;
    q_cmd.force_req    = clamp_req(force_request);
    q_cmd.periodic_req = clamp_req(periodic_request);
    q_cmd.range_req    = range_request;
    case (kind)
      wesfl_pkg::KIND_POSITION: q_cmd.op = wesfl_pkg::OP_POSITION;
      wesfl_pkg::KIND_FORCE:    q_cmd.op = wesfl_pkg::OP_FORCE;
      wesfl_pkg::KIND_RANGE: begin
        // out-of-window ranges are rejected here so the back never checks
        if (range_request < wesfl_pkg::MIN_RANGE || range_request > wesfl_pkg::FULL_RANGE) begin
          q_cmd.op = wesfl_pkg::OP_REJECT;
        end else begin
          q_cmd.op = wesfl_pkg::OP_RANGE;
        end
      end
      wesfl_pkg::KIND_STOP_ALL: q_cmd.op = wesfl_pkg::OP_STOP_ALL;
      default:                  q_cmd.op = wesfl_pkg::OP_STOP_ALL;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/wesfl_fifo.sv @@
// short command queue between front and back
`default_nettype none
module wesfl_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire wesfl_pkg::cmd_t  push_cmd,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output wesfl_pkg::cmd_t       head
);

  wesfl_pkg::cmd_t                   mem [wesfl_pkg::FIFO_DEPTH];
  logic [wesfl_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [wesfl_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [wesfl_pkg::FIFO_CNT_W-1:0]  count;

  assign full      = (count == wesfl_pkg::FIFO_CNT_W'(wesfl_pkg::FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/wesfl_scale.sv @@
// gain scaling unit: gain products, divided by 1e4 and 1e8 with reciprocal multiplies
`default_nettype none
module wesfl_scale (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic signed [wesfl_pkg::FORCE_W-1:0]   force_req,
  input  wire logic signed [wesfl_pkg::FORCE_W-1:0]   periodic_req,
  input  wire logic [wesfl_pkg::GAIN_W-1:0]           overall_gain,
  input  wire logic [wesfl_pkg::GAIN_W-1:0]           periodic_gain,
  output logic                                        done,
  output logic signed [wesfl_pkg::FORCE_W-1:0]        result
);

  typedef enum logic [7:0] {
    SC_IDLE = 8'b00000001,
    SC_MUL  = 8'b00000010,
    SC_QUO  = 8'b00000100,
    SC_REM  = 8'b00001000,
    SC_RMUL = 8'b00010000,
    SC_RDIV = 8'b00100000,
    SC_QB   = 8'b01000000,
    SC_FIN  = 8'b10000000
  } sc_state_t;

  sc_state_t                              state;
  logic                                   sign_a;
  logic                                   sign_b;
  logic [wesfl_pkg::GAIN_W-1:0]           mag_f;
  logic [wesfl_pkg::GAIN_W-1:0]           mag_p;
  logic [wesfl_pkg::GAIN_W-1:0]           og;
  logic [wesfl_pkg::GAIN_W-1:0]           pg;
  logic [wesfl_pkg::PROD_W-1:0]           prod_a;
  logic [wesfl_pkg::PROD_W-1:0]           prod_t;
  logic [wesfl_pkg::QUOT_W-1:0]           quot_a;
  logic [wesfl_pkg::QUOT_W-1:0]           quot_t;
  logic [wesfl_pkg::REM_W-1:0]            rem_t;
  logic [wesfl_pkg::PROD_W-1:0]           part_q;
  logic [wesfl_pkg::PROD_W-1:0]           part_r;
  logic [wesfl_pkg::DIV_IN_W-1:0]         sum_w;
  logic [wesfl_pkg::QUOT_W-1:0]           quot_b;
  logic signed [wesfl_pkg::SUM_W-1:0]     term_a;
  logic signed [wesfl_pkg::SUM_W-1:0]     term_b;
  logic signed [wesfl_pkg::SUM_W-1:0]     sum;
  logic signed [wesfl_pkg::FORCE_W-1:0]   abs_f;
  logic signed [wesfl_pkg::FORCE_W-1:0]   abs_p;

  // floor(x / 1e4) by multiplying with the scaled reciprocal
  function automatic logic [wesfl_pkg::QUOT_W-1:0] div_1e4(
    input logic [wesfl_pkg::DIV_IN_W-1:0] x
  );
    logic [wesfl_pkg::DIV_IN_W+wesfl_pkg::RECIP_W-1:0] p;
    p = (wesfl_pkg::DIV_IN_W + wesfl_pkg::RECIP_W)'(x) *
        (wesfl_pkg::DIV_IN_W + wesfl_pkg::RECIP_W)'(wesfl_pkg::RECIP_1E4);
    return p[wesfl_pkg::RECIP_SHIFT +: wesfl_pkg::QUOT_W];
  endfunction

  assign abs_f = force_req[wesfl_pkg::FORCE_W-1] ? -force_req : force_req;
  assign abs_p = periodic_req[wesfl_pkg::FORCE_W-1] ? -periodic_req : periodic_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      case (state)
        SC_IDLE: if (start) state <= SC_MUL;
        SC_MUL:  state <= SC_QUO;
        SC_QUO:  state <= SC_REM;
        SC_REM:  state <= SC_RMUL;
        SC_RMUL: state <= SC_RDIV;
        SC_RDIV: state <= SC_QB;
        SC_QB:   state <= SC_FIN;
        SC_FIN:  state <= SC_IDLE;
        default: state <= SC_IDLE;
      endcase
    end
  end

  // periodic part: t = q*1e4 + r, so t*og/1e8 = (q*og + r*og/1e4)/1e4
  always_ff @(posedge clk) begin
    case (state)
      SC_IDLE: begin
        if (start) begin
          sign_a <= force_req[wesfl_pkg::FORCE_W-1];
          sign_b <= periodic_req[wesfl_pkg::FORCE_W-1];
          mag_f  <= abs_f[wesfl_pkg::GAIN_W-1:0];
          mag_p  <= abs_p[wesfl_pkg::GAIN_W-1:0];
          og     <= overall_gain;
          pg     <= periodic_gain;
        end
      end
      SC_MUL: begin
        prod_a <= wesfl_pkg::PROD_W'(mag_f) * wesfl_pkg::PROD_W'(og);
        prod_t <= wesfl_pkg::PROD_W'(mag_p) * wesfl_pkg::PROD_W'(pg);
      end
      SC_QUO: begin
        quot_a <= div_1e4(wesfl_pkg::DIV_IN_W'(prod_a));
        quot_t <= div_1e4(wesfl_pkg::DIV_IN_W'(prod_t));
      end
      SC_REM: begin
        rem_t  <= wesfl_pkg::REM_W'(prod_t - wesfl_pkg::PROD_W'(quot_t) *
                                    wesfl_pkg::PROD_W'(wesfl_pkg::DIV_SCALE));
        part_q <= wesfl_pkg::PROD_W'(quot_t) * wesfl_pkg::PROD_W'(og);
      end
      SC_RMUL: begin
        part_r <= wesfl_pkg::PROD_W'(rem_t) * wesfl_pkg::PROD_W'(og);
      end
      SC_RDIV: begin
        sum_w <= wesfl_pkg::DIV_IN_W'(part_q) +
                 wesfl_pkg::DIV_IN_W'(div_1e4(wesfl_pkg::DIV_IN_W'(part_r)));
      end
      SC_QB: begin
        quot_b <= div_1e4(sum_w);
      end
      default: begin
      end
    endcase
  end

  // truncation toward zero: sign applied to the floored magnitudes
  assign term_a = sign_a ? -$signed({1'b0, quot_a}) : $signed({1'b0, quot_a});
  assign term_b = sign_b ? -$signed({1'b0, quot_b}) : $signed({1'b0, quot_b});
  assign sum    = term_a + term_b;

  always_comb begin
    if (sum > wesfl_pkg::SUM_W'(wesfl_pkg::FORCE_LIMIT)) begin
      result = wesfl_pkg::FORCE_W'(wesfl_pkg::FORCE_LIMIT);
    end else if (sum < -wesfl_pkg::SUM_W'(wesfl_pkg::FORCE_LIMIT)) begin
      result = -wesfl_pkg::FORCE_W'(wesfl_pkg::FORCE_LIMIT);
    end else begin
      result = sum[wesfl_pkg::FORCE_W-1:0];
    end
  end

  assign done = (state == SC_FIN);

endmodule
`default_nettype wire

@@ hw/rtl/wesfl_back.sv @@
// back end: settings, lock state, base force and the result register
`default_nettype none
module wesfl_back (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [wesfl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wesfl_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                                q_not_empty,
  input  wire wesfl_pkg::cmd_t                     q_head,
  output logic                                     q_pop,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output wesfl_pkg::result_t                       out_item
);

  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_SCALE = 3'b010,
    BK_BASE  = 3'b100
  } bk_state_t;

  bk_state_t                              state;
  logic [wesfl_pkg::GAIN_W-1:0]           overall_gain;
  logic [wesfl_pkg::GAIN_W-1:0]           periodic_gain;
  logic [wesfl_pkg::BND_W-1:0]            boundary_force;
  logic [wesfl_pkg::POS_W-1:0]            engage_low;
  logic [wesfl_pkg::POS_W-1:0]            release_low;
  logic [wesfl_pkg::POS_W-1:0]            engage_high;
  logic [wesfl_pkg::POS_W-1:0]            release_high;
  logic [wesfl_pkg::RANGE_W-1:0]          range_in_use;
  logic signed [wesfl_pkg::FORCE_W-1:0]   base_force;
  wesfl_pkg::lock_t                       lock_side;
  wesfl_pkg::lock_t                       lock_next;
  logic                                   out_free;
  logic                                   needs_out;
  logic                                   take;
  logic                                   load;
  wesfl_pkg::result_t                     load_item;
  wesfl_pkg::result_t                     base_item;
  logic signed [wesfl_pkg::FORCE_W-1:0]   bnd_pos;
  logic                                   scale_start;
  logic                                   scale_done;
  logic signed [wesfl_pkg::FORCE_W-1:0]   scale_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      overall_gain   <= wesfl_pkg::RST_OVERALL_GAIN;
      periodic_gain  <= wesfl_pkg::RST_PERIODIC_GAIN;
      boundary_force <= wesfl_pkg::RST_BOUNDARY;
      engage_low     <= wesfl_pkg::RST_ENGAGE_LOW;
      release_low    <= wesfl_pkg::RST_RELEASE_LOW;
      engage_high    <= wesfl_pkg::RST_ENGAGE_HIGH;
      release_high   <= wesfl_pkg::RST_RELEASE_HIGH;
    end else if (cfg_valid) begin
      case (wesfl_pkg::cfg_reg_t'(cfg_index))
        wesfl_pkg::CFG_OVERALL_GAIN:  overall_gain   <= cfg_data;
        wesfl_pkg::CFG_PERIODIC_GAIN: periodic_gain  <= cfg_data;
        wesfl_pkg::CFG_BOUNDARY:      boundary_force <= cfg_data[wesfl_pkg::BND_W-1:0];
        wesfl_pkg::CFG_ENGAGE_LOW:    engage_low     <= cfg_data;
        wesfl_pkg::CFG_RELEASE_LOW:   release_low    <= cfg_data;
        wesfl_pkg::CFG_ENGAGE_HIGH:   engage_high    <= cfg_data;
        wesfl_pkg::CFG_RELEASE_HIGH:  release_high   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // hysteresis lock transition for a position sample
  always_comb begin
    lock_next = lock_side;
    if (range_in_use < wesfl_pkg::FULL_RANGE) begin
      case (lock_side)
        wesfl_pkg::LOCK_NONE: begin
          if (q_head.position <= engage_low) begin
            lock_next = wesfl_pkg::LOCK_LOW;
          end else if (q_head.position >= engage_high) begin
            lock_next = wesfl_pkg::LOCK_HIGH;
          end
        end
        wesfl_pkg::LOCK_LOW: begin
          if (q_head.position >= release_low) lock_next = wesfl_pkg::LOCK_NONE;
        end
        wesfl_pkg::LOCK_HIGH: begin
          if (q_head.position <= release_high) lock_next = wesfl_pkg::LOCK_NONE;
        end
        default: lock_next = wesfl_pkg::LOCK_NONE;
      endcase
    end
  end

  // zero base force goes out as a slot stop
  always_comb begin
    base_item.range_value = '0;
    base_item.last        = 1'b1;
    if (base_force == '0) begin
      base_item.action      = wesfl_pkg::ACT_STOP_SLOT;
      base_item.force_value = '0;
    end else begin
      base_item.action      = wesfl_pkg::ACT_SET_FORCE;
      base_item.force_value = base_force;
    end
  end

  assign bnd_pos  = $signed({2'b00, boundary_force});
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (q_head.op)
      wesfl_pkg::OP_POSITION: needs_out = (lock_next != lock_side);
      wesfl_pkg::OP_FORCE:    needs_out = 1'b0;
      default:                needs_out = 1'b1;
    endcase
  end

  assign take        = (state == BK_IDLE) && q_not_empty && (!needs_out || out_free);
  assign q_pop       = take;
  assign scale_start = take && (q_head.op == wesfl_pkg::OP_FORCE);

  always_comb begin
    load      = 1'b0;
    load_item = base_item;
    if (take) begin
      case (q_head.op)
        wesfl_pkg::OP_POSITION: begin
          load = needs_out;
          case (lock_next)
            wesfl_pkg::LOCK_LOW: begin
              load_item.action      = wesfl_pkg::ACT_SET_FORCE;
              load_item.force_value = -bnd_pos;
            end
            wesfl_pkg::LOCK_HIGH: begin
              load_item.action      = wesfl_pkg::ACT_SET_FORCE;
              load_item.force_value = bnd_pos;
            end
            default: load_item = base_item;
          endcase
        end
        wesfl_pkg::OP_RANGE: begin
          load                  = 1'b1;
          load_item.action      = wesfl_pkg::ACT_SET_RANGE;
          load_item.force_value = '0;
          load_item.range_value = q_head.range_req;
          load_item.last        = !((q_head.range_req == wesfl_pkg::FULL_RANGE) &&
                                    (lock_side != wesfl_pkg::LOCK_NONE));
        end
        wesfl_pkg::OP_REJECT: begin
          load                  = 1'b1;
          load_item.action      = wesfl_pkg::ACT_REJECTED;
          load_item.force_value = '0;
        end
        wesfl_pkg::OP_STOP_ALL: begin
          load                  = 1'b1;
          load_item.action      = wesfl_pkg::ACT_STOP_ALL;
          load_item.force_value = '0;
        end
        default: load = 1'b0;
      endcase
    end else if (state == BK_BASE && out_free) begin
      load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      range_in_use <= wesfl_pkg::FULL_RANGE;
      base_force   <= '0;
      lock_side    <= wesfl_pkg::LOCK_NONE;
      out_valid    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        BK_IDLE: begin
          if (take) begin
            case (q_head.op)
              wesfl_pkg::OP_POSITION: lock_side <= lock_next;
              wesfl_pkg::OP_FORCE:    state <= BK_SCALE;
              wesfl_pkg::OP_RANGE: begin
                range_in_use <= q_head.range_req;
                // full range releases a held lock and restores the base force
                if (q_head.range_req == wesfl_pkg::FULL_RANGE &&
                    lock_side != wesfl_pkg::LOCK_NONE) begin
                  lock_side <= wesfl_pkg::LOCK_NONE;
                  state     <= BK_BASE;
                end
              end
              wesfl_pkg::OP_STOP_ALL: begin
                base_force <= '0;
                lock_side  <= wesfl_pkg::LOCK_NONE;
              end
              default: begin
              end
            endcase
          end
        end
        BK_SCALE: begin
          if (scale_done) begin
            base_force <= scale_result;
            state      <= (lock_side == wesfl_pkg::LOCK_NONE) ? BK_BASE : BK_IDLE;
          end
        end
        BK_BASE: begin
          if (out_free) state <= BK_IDLE;
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

  wesfl_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .start         (scale_start),
    .force_req     (q_head.force_req),
    .periodic_req  (q_head.periodic_req),
    .overall_gain  (overall_gain),
    .periodic_gain (periodic_gain),
    .done          (scale_done),
    .result        (scale_result)
  );

endmodule
`default_nettype wire
